@@ design/rrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_pkg : shared types and constants
// Field widths, register indices and the structs passed from the
// configuration block to the pipeline halves and between the two halves.
// ----------------------------------------------------------------------------
package rrf_pkg;

   localparam int COL_W              = 12;
   localparam int DIM_W              = 13;
   localparam int RAD_W              = 12;
   localparam int SCR_W              = 14;
   localparam int COLOR_W            = 32;
   localparam int ADDR_W             = 24;
   localparam int SQ_W               = 2 * RAD_W;
   localparam int PROD_W             = 2 * DIM_W;
   localparam int CSR_IDX_W          = 3;
   localparam int CSR_DATA_W         = 13;
   localparam int REQ_DATA_W         = 56;
   localparam int RSP_DATA_W         = 56;
   localparam int COORD_BITS_DEFAULT = 12;

   localparam logic [CSR_IDX_W-1:0] REG_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SURF_W = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SURF_H = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE = 3'd7;

   typedef struct packed {
      logic [DIM_W-1:0] left;
      logic [DIM_W-1:0] top;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [RAD_W-1:0] radius;
      logic [DIM_W-1:0] surf_w;
      logic [DIM_W-1:0] surf_h;
      logic [DIM_W-1:0] stride;
   } rrf_cfg_type;

   typedef struct packed {
      logic               valid;
      logic               ok;
      logic               corner;
      logic [RAD_W-1:0]   dx;
      logic [RAD_W-1:0]   dy;
      logic [RAD_W-1:0]   radius;
      logic [DIM_W-1:0]   row;
      logic [DIM_W-1:0]   col;
      logic [COLOR_W-1:0] color;
   } rrf_geo_type;

endpackage

@@ design/rounded_rect_fill_pixel_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_fill_pixel_top : rounded rectangle pixel fill test
// Usage:
//   req_ beats carry a pixel position relative to the rectangle's top-left
//   corner and a fill colour. Each beat yields exactly one rsp_ beat with the
//   write strobe in rsp_tuser and the linear address and colour in rsp_tdata.
//   The address is zero whenever the strobe is low.
//   Rectangle, radius and surface geometry are set through the csr_ port and
//   must be written only while no beats are in flight; the block does not enforce it.
// Pipeline: five register stages lie between an accepted req_ beat and rsp_tvalid
//   (bounds and radius clamp, clip, corner mirror, squares and row product,
//   compare and address add).
// Throughput: one beat per cycle while rsp_tready is high.
// Stall: when the output register holds an untaken beat the whole pipeline
//   freezes and req_tready drops in the same cycle; nothing is lost.
// Reset: synchronous; empties the pipeline and clears the configuration registers to zero.
// ----------------------------------------------------------------------------
module rounded_rect_fill_pixel_top #(
   parameter int COORD_BITS = rrf_pkg::COORD_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [11:0] local_col, [23:12] local_row, [55:24] fill_color
   input  logic [rrf_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [23:0] pixel_address, [55:24] pixel_color
   output logic [rrf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [0] write_strobe
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [rrf_pkg::CSR_IDX_W-1:0]     csr_addr,
   input  logic [rrf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rrf_pkg::*;

   rrf_cfg_type        cfg;
   rrf_geo_type        geo;
   logic               pipe_en;
   logic               out_strobe;
   logic [ADDR_W-1:0]  out_addr;
   logic [COLOR_W-1:0] out_color;

   rrf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rrf_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .pipe_en  (pipe_en),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_col   (req_tdata[COL_W-1:0]),
      .in_row   (req_tdata[2*COL_W-1:COL_W]),
      .in_color (req_tdata[2*COL_W+COLOR_W-1:2*COL_W]),
      .geo      (geo)
   );

   rrf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .geo        (geo),
      .cfg        (cfg),
      .out_ready  (rsp_tready),
      .pipe_en    (pipe_en),
      .out_valid  (rsp_tvalid),
      .out_strobe (out_strobe),
      .out_addr   (out_addr),
      .out_color  (out_color)
   );

   assign req_tready = pipe_en;
   assign rsp_tuser  = out_strobe;
   assign rsp_tdata  = {out_color, out_addr};

   a_blank_addr : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[ADDR_W-1:0] == '0))
      else $error("address not zero on a beat without strobe");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while output stalled");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tuser)))
      else $error("stalled output beat changed");

endmodule

@@ design/rrf_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_csr : configuration registers
// Write-only register file, one register per index, cleared by reset.
// ----------------------------------------------------------------------------
module rrf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rrf_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [rrf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output rrf_pkg::rrf_cfg_type             cfg
);
   import rrf_pkg::*;

   rrf_cfg_type cfg_ff;
   rrf_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_LEFT:   cfg_in.left   = csr_wdata;
            REG_TOP:    cfg_in.top    = csr_wdata;
            REG_WIDTH:  cfg_in.width  = csr_wdata;
            REG_HEIGHT: cfg_in.height = csr_wdata;
            REG_RADIUS: cfg_in.radius = csr_wdata[RAD_W-1:0];
            REG_SURF_W: cfg_in.surf_w = csr_wdata;
            REG_SURF_H: cfg_in.surf_h = csr_wdata;
            REG_STRIDE: cfg_in.stride = csr_wdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/rrf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_front : geometry stages 1 to 3
// Rectangle bounds, radius clamp, surface clip, corner mirroring and the
// distance offsets from the corner circle's centre.
// ----------------------------------------------------------------------------
module rrf_front #(
   parameter int COORD_BITS = rrf_pkg::COORD_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pipe_en,
   input  rrf_pkg::rrf_cfg_type           cfg,
   input  logic                           in_valid,
   input  logic [rrf_pkg::COL_W-1:0]      in_col,
   input  logic [rrf_pkg::COL_W-1:0]      in_row,
   input  logic [rrf_pkg::COLOR_W-1:0]    in_color,
   output rrf_pkg::rrf_geo_type           geo
);
   import rrf_pkg::*;

   localparam int EFF_BITS = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;
   localparam logic [COL_W-1:0] COORD_MASK = COL_W'((64'd1 << EFF_BITS) - 64'd1);

   // stage 1
   logic               s1_valid_ff;
   logic [COL_W-1:0]   s1_lx_ff, s1_ly_ff, s1_lx_in, s1_ly_in;
   logic [COLOR_W-1:0] s1_color_ff;
   logic               s1_in_rect_ff, s1_in_rect_in;
   logic [RAD_W-1:0]   s1_r_ff, s1_r_in;
   logic [SCR_W-1:0]   s1_sx_ff, s1_sy_ff, s1_sx_in, s1_sy_in;

   // stage 2
   logic               s2_valid_ff;
   logic [COL_W-1:0]   s2_lx_ff, s2_ly_ff;
   logic [COLOR_W-1:0] s2_color_ff;
   logic               s2_ok_ff, s2_ok_in;
   logic [RAD_W-1:0]   s2_r_ff, s2_r_in;
   logic [DIM_W-1:0]   s2_row_ff, s2_col_ff;

   // stage 3
   rrf_geo_type        s3_ff, s3_in;
   logic [DIM_W-1:0]   x_lim, y_lim, x_m, y_m;

   always_comb begin
      s1_lx_in      = in_col & COORD_MASK;
      s1_ly_in      = in_row & COORD_MASK;
      s1_in_rect_in = ({1'b0, s1_lx_in} < cfg.width) && ({1'b0, s1_ly_in} < cfg.height);
      s1_r_in       = ({cfg.radius, 1'b0} > cfg.width) ? cfg.width[DIM_W-1:1] : cfg.radius;
      s1_sx_in      = {cfg.left[DIM_W-1], cfg.left} + {2'b00, s1_lx_in};
      s1_sy_in      = {cfg.top[DIM_W-1], cfg.top} + {2'b00, s1_ly_in};
   end

   always_comb begin
      s2_r_in  = ({s1_r_ff, 1'b0} > cfg.height) ? cfg.height[DIM_W-1:1] : s1_r_ff;
      s2_ok_in = s1_in_rect_ff && !s1_sx_ff[SCR_W-1] && !s1_sy_ff[SCR_W-1]
                 && (s1_sx_ff[DIM_W-1:0] < cfg.surf_w)
                 && (s1_sy_ff[DIM_W-1:0] < cfg.surf_h);
   end

   always_comb begin
      x_lim = cfg.width - {1'b0, s2_r_ff};
      y_lim = cfg.height - {1'b0, s2_r_ff};
      x_m   = ({1'b0, s2_lx_ff} >= x_lim) ? (cfg.width - 13'd1 - {1'b0, s2_lx_ff})
                                          : {1'b0, s2_lx_ff};
      y_m   = ({1'b0, s2_ly_ff} >= y_lim) ? (cfg.height - 13'd1 - {1'b0, s2_ly_ff})
                                          : {1'b0, s2_ly_ff};
      s3_in.valid  = s2_valid_ff;
      s3_in.ok     = s2_ok_ff;
      s3_in.corner = (x_m < {1'b0, s2_r_ff}) && (y_m < {1'b0, s2_r_ff});
      s3_in.dx     = s2_r_ff - x_m[RAD_W-1:0];
      s3_in.dy     = s2_r_ff - y_m[RAD_W-1:0];
      s3_in.radius = s2_r_ff;
      s3_in.row    = s2_row_ff;
      s3_in.col    = s2_col_ff;
      s3_in.color  = s2_color_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_ff.valid <= s3_in.valid;
      end

      if (pipe_en) begin
         s1_lx_ff      <= s1_lx_in;
         s1_ly_ff      <= s1_ly_in;
         s1_color_ff   <= in_color;
         s1_in_rect_ff <= s1_in_rect_in;
         s1_r_ff       <= s1_r_in;
         s1_sx_ff      <= s1_sx_in;
         s1_sy_ff      <= s1_sy_in;

         s2_lx_ff      <= s1_lx_ff;
         s2_ly_ff      <= s1_ly_ff;
         s2_color_ff   <= s1_color_ff;
         s2_ok_ff      <= s2_ok_in;
         s2_r_ff       <= s2_r_in;
         s2_row_ff     <= s1_sy_ff[DIM_W-1:0];
         s2_col_ff     <= s1_sx_ff[DIM_W-1:0];

         s3_ff.ok      <= s3_in.ok;
         s3_ff.corner  <= s3_in.corner;
         s3_ff.dx      <= s3_in.dx;
         s3_ff.dy      <= s3_in.dy;
         s3_ff.radius  <= s3_in.radius;
         s3_ff.row     <= s3_in.row;
         s3_ff.col     <= s3_in.col;
         s3_ff.color   <= s3_in.color;
      end
   end

   assign geo = s3_ff;

endmodule

@@ design/rrf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrf_back : squares, address product and output register (stages 4 and 5)
// Also owns the pipeline advance enable derived from the output register.
// ----------------------------------------------------------------------------
module rrf_back (
   input  logic                           clock,
   input  logic                           reset,
   input  rrf_pkg::rrf_geo_type           geo,
   input  rrf_pkg::rrf_cfg_type           cfg,
   input  logic                           out_ready,
   output logic                           pipe_en,
   output logic                           out_valid,
   output logic                           out_strobe,
   output logic [rrf_pkg::ADDR_W-1:0]     out_addr,
   output logic [rrf_pkg::COLOR_W-1:0]    out_color
);
   import rrf_pkg::*;

   // stage 4
   logic               s4_valid_ff;
   logic               s4_ok_ff, s4_corner_ff;
   logic [SQ_W-1:0]    s4_dx2_ff, s4_dy2_ff, s4_rr_ff;
   logic [PROD_W-1:0]  s4_prod_ff;
   logic [DIM_W-1:0]   s4_col_ff;
   logic [COLOR_W-1:0] s4_color_ff;

   // stage 5, output register
   logic               s5_valid_ff;
   logic               s5_strobe_ff, s5_strobe_in;
   logic [ADDR_W-1:0]  s5_addr_ff, s5_addr_in;
   logic [COLOR_W-1:0] s5_color_ff;
   logic [SQ_W:0]      dist_sum;

   assign pipe_en = !s5_valid_ff || out_ready;

   always_comb begin
      dist_sum     = {1'b0, s4_dx2_ff} + {1'b0, s4_dy2_ff};
      s5_strobe_in = s4_ok_ff && (!s4_corner_ff || (dist_sum <= {1'b0, s4_rr_ff}));
      s5_addr_in   = s5_strobe_in
                     ? (s4_prod_ff[ADDR_W-1:0] + {{(ADDR_W-DIM_W){1'b0}}, s4_col_ff})
                     : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s4_valid_ff <= geo.valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_ok_ff     <= geo.ok;
         s4_corner_ff <= geo.corner;
         s4_dx2_ff    <= SQ_W'(geo.dx) * SQ_W'(geo.dx);
         s4_dy2_ff    <= SQ_W'(geo.dy) * SQ_W'(geo.dy);
         s4_rr_ff     <= SQ_W'(geo.radius) * SQ_W'(geo.radius);
         s4_prod_ff   <= PROD_W'(geo.row) * PROD_W'(cfg.stride);
         s4_col_ff    <= geo.col;
         s4_color_ff  <= geo.color;

         s5_strobe_ff <= s5_strobe_in;
         s5_addr_ff   <= s5_addr_in;
         s5_color_ff  <= s4_color_ff;
      end
   end

   assign out_valid  = s5_valid_ff;
   assign out_strobe = s5_strobe_ff;
   assign out_addr   = s5_addr_ff;
   assign out_color  = s5_color_ff;

endmodule
